// File: rtl/timer_counter_8bit_prescaled_unit_macros.svh
// Assertion macros used by the timer/counter checker.
`ifndef TIMER_COUNTER_8BIT_PRESCALED_UNIT_MACROS_SVH
`define TIMER_COUNTER_8BIT_PRESCALED_UNIT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define TC8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that stays live through reset.
`define TC8_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tc8_pkg.sv
// Shared types, codes and tables for the prescaled 8-bit timer/counter.
package tc8_pkg;

  typedef enum logic [1:0] {
    CMD_TICK           = 2'd0,
    CMD_WRITE          = 2'd1,
    CMD_CLEAR_OVF      = 2'd2,
    CMD_PRESCALE_RESET = 2'd3
  } cmd_t;

  // clock_select codes
  localparam logic [2:0] CS_STOPPED  = 3'd0;
  localparam logic [2:0] CS_DIV1     = 3'd1;
  localparam logic [2:0] CS_DIV8     = 3'd2;
  localparam logic [2:0] CS_DIV64    = 3'd3;
  localparam logic [2:0] CS_DIV256   = 3'd4;
  localparam logic [2:0] CS_DIV1024  = 3'd5;
  localparam logic [2:0] CS_PIN_FALL = 3'd6;
  localparam logic [2:0] CS_PIN_RISE = 3'd7;

  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_CLOCK_SELECT = 1'b0;

  localparam int EDGE_DELAY_DEPTH_DEFAULT = 4;

  typedef struct packed {
    cmd_t       cmd;
    logic       pin_level;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic       counted;
    logic       overflow_flag;
    logic [7:0] count_value;
  } result_t;

  // Low prescaler bits that must be zero for a count in internal modes.
  function automatic logic [9:0] div_mask(input logic [2:0] cs);
    logic [9:0] m;
    unique case (cs)
      CS_DIV8:    m = 10'd7;
      CS_DIV64:   m = 10'd63;
      CS_DIV256:  m = 10'd255;
      CS_DIV1024: m = 10'd1023;
      CS_STOPPED, CS_DIV1, CS_PIN_FALL, CS_PIN_RISE: m = 10'd0;
      default:    m = 10'd0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/tc8_core.sv
// Timer state and single-pass next-state logic for one item.
module tc8_core import tc8_pkg::*; #(
  parameter int EDGE_DELAY_DEPTH = EDGE_DELAY_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  input  logic [2:0] clock_select,
  output result_t    result
);

  localparam int IDX_W = $clog2(EDGE_DELAY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EDGE_DELAY_DEPTH - 1);

  logic [7:0]                  counter, counter_next;
  logic                        overflow, overflow_next;
  logic [9:0]                  prescale_count, prescale_count_next;
  logic                        pin_previous, pin_previous_next;
  logic [EDGE_DELAY_DEPTH-1:0] slots, slots_next;
  logic [IDX_W-1:0]            slot_in, slot_in_next;
  logic [IDX_W-1:0]            slot_out, slot_out_next;
  logic                        pending, pending_next;
  logic                        inc;
  logic                        edge_hit;

  always_comb begin
    counter_next        = counter;
    overflow_next       = overflow;
    prescale_count_next = prescale_count;
    pin_previous_next   = pin_previous;
    slots_next          = slots;
    slot_in_next        = slot_in;
    slot_out_next       = slot_out;
    pending_next        = pending;
    inc                 = 1'b0;
    edge_hit            = 1'b0;

    unique case (item.cmd)
      CMD_TICK: begin
        pin_previous_next = item.pin_level;
        edge_hit = (clock_select == CS_PIN_FALL && pin_previous && !item.pin_level) ||
                   (clock_select == CS_PIN_RISE && !pin_previous && item.pin_level);
        if (edge_hit) begin
          slots_next[slot_in] = 1'b1;
        end
        priority if (clock_select == CS_STOPPED) begin
          inc = 1'b0;
        end else if (clock_select >= CS_PIN_FALL) begin
          inc = slots_next[slot_out];
          slots_next[slot_out] = 1'b0;
          slot_in_next  = (slot_in == IDX_LAST) ? '0 : slot_in + 1'b1;
          slot_out_next = (slot_out == IDX_LAST) ? '0 : slot_out + 1'b1;
        end else begin
          prescale_count_next = prescale_count + 10'd1;
          inc = ((prescale_count_next & div_mask(clock_select)) == 10'd0);
          if (pending) begin
            prescale_count_next = '0;
            pending_next        = 1'b0;
          end
          slots_next = '0;
        end
      end
      CMD_WRITE:          counter_next  = item.write_value;
      CMD_CLEAR_OVF:      overflow_next = 1'b0;
      CMD_PRESCALE_RESET: pending_next  = 1'b1;
      default:            pending_next  = pending;
    endcase

    if (inc) begin
      if (counter == 8'hff) begin
        counter_next  = '0;
        overflow_next = 1'b1;
      end else begin
        counter_next = counter + 8'd1;
      end
    end

    result.count_value   = counter_next;
    result.overflow_flag = overflow_next;
    result.counted       = inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      overflow       <= 1'b0;
      prescale_count <= '0;
      pin_previous   <= 1'b0;
      slots          <= '0;
      slot_in        <= '0;
      slot_out       <= IDX_LAST;
      pending        <= 1'b0;
    end else if (accept) begin
      counter        <= counter_next;
      overflow       <= overflow_next;
      prescale_count <= prescale_count_next;
      pin_previous   <= pin_previous_next;
      slots          <= slots_next;
      slot_in        <= slot_in_next;
      slot_out       <= slot_out_next;
      pending        <= pending_next;
    end
  end

endmodule

// File: rtl/timer_counter_8bit_prescaled_unit.sv
// Top level of the prescaled 8-bit timer/counter: stream ports, register port, output skid.
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------
//  s_*       | in        | items: tuser cmd, tdata pin_level/write_value
//  m_*       | out       | results: count_value, overflow_flag, counted
//  APB       | in/out    | clock_select register at byte address 0
//
// One item per cycle while s_tready is high: each transfer updates the timer state in
// the cycle it is taken; its result is registered in the output register or the skid.
// A two-deep output (register plus skid) keeps s_tready high for one more
// transfer while m_tready is low; it drops only once both stages are full.
// Synchronous reset clears the timer state, clock_select and both stages.
module timer_counter_8bit_prescaled_unit import tc8_pkg::*; #(
  parameter int EDGE_DELAY_DEPTH = EDGE_DELAY_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [0] pin_level, [8:1] write_value, rest zero
  input  logic [1:0]            s_tuser,   // [1:0] cmd
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [7:0] count_value, [8] overflow_flag,
                                           // [9] counted, rest zero
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [2:0] clock_select;
  logic       accept;
  logic       take;
  item_t      item;
  result_t    result;
  result_t    out_data, skid_data;
  logic       out_valid, skid_valid;
  logic       reg_hit;

  // Register port: always ready, one register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_CLOCK_SELECT);
  assign prdata  = reg_hit ? {29'd0, clock_select} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_select <= CS_STOPPED;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      clock_select <= pwdata[2:0];
    end
  end

  // Input unpacking
  assign item.cmd         = cmd_t'(s_tuser);
  assign item.pin_level   = s_tdata[0];
  assign item.write_value = s_tdata[8:1];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;

  tc8_core #(
    .EDGE_DELAY_DEPTH(EDGE_DELAY_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .clock_select (clock_select),
    .result       (result)
  );

  // Output register with skid stage; the skid fills only while a result stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_data.counted, out_data.overflow_flag, out_data.count_value};

endmodule

// File: rtl/tc8_checker.sv
// Port-level checks for the timer/counter, bound to the top level.
`include "timer_counter_8bit_prescaled_unit_macros.svh"

module tc8_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result holds
  `TC8_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  // a counted wrap to zero must show the flag
  `TC8_ASSERT(a_wrap_flag, m_tvalid && m_tdata[9] && m_tdata[7:0] == 8'd0 |-> m_tdata[8], "wrap without overflow flag")
  // empty output means room for a transfer
  `TC8_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
  // nothing leaves right after reset
  `TC8_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_tvalid, "result present after reset")

endmodule

bind timer_counter_8bit_prescaled_unit tc8_checker u_tc8_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
